>>> design/tdpt_pkg.sv
// Package for the trial-division prime test core.
// Holds the sequencer state type, divider status type and fixed field widths.
// No dependencies.
package tdpt_pkg;

   // Fixed widths of the transaction fields
   localparam int unsigned VALUE_PORT_WIDTH = 32;
   localparam int unsigned COUNT_WIDTH      = 32;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCREEN,
      ST_DIVIDE,
      ST_FINISH
   } tdpt_state_type;

   typedef struct packed {
      logic done;      // one-cycle pulse, quotient and remainder settled
      logic rem_zero;  // remainder is zero
   } tdpt_div_status_type;

endpackage

>>> design/trial_division_prime_test_core.sv
// Trial-division prime test core: one verdict and a running prime count per transaction.
// Verdicts for 2, even numbers and numbers below 2 are decided in the screen state;
// otherwise odd divisors from 3 are tried in turn until one divides or passes the root,
// each through the bit-serial divider and one deciding step. One transaction at a time;
// the next is taken the cycle after the verdict loads the output register.
// Reset: synchronous, active high.
module trial_division_prime_test_core
   import tdpt_pkg::*;
#(
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [VALUE_PORT_WIDTH-1:0] req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_is_prime,
   output logic [COUNT_WIDTH-1:0]      rsp_primes_seen
);

   // Bits of the value that take part; higher port bits are ignored
   localparam int unsigned NW = (VALUE_WIDTH < VALUE_PORT_WIDTH) ? VALUE_WIDTH
                                                                  : VALUE_PORT_WIDTH;

   tdpt_state_type          state_ff, state_in;
   logic [NW-1:0]           n_ff, n_in;           // number under test
   logic [NW-1:0]           d_ff, d_in;           // current odd divisor
   logic                    verdict_ff, verdict_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_is_prime_ff, rsp_is_prime_in;

   logic                    div_start;
   logic [NW-1:0]           quotient;
   tdpt_div_status_type     div_status;

   // Remainder and quotient of n / d, one bit a cycle.
   // d <= n / d is the square bound taken without a multiplier and without wrap.
   tdpt_divider #(
      .WIDTH (NW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (n_ff),
      .divisor  (d_ff),
      .quotient (quotient),
      .status   (div_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
      n_ff            <= n_in;
      d_ff            <= d_in;
      verdict_ff      <= verdict_in;
      rsp_is_prime_ff <= rsp_is_prime_in;
   end

   always_comb begin
      state_in        = state_ff;
      n_in            = n_ff;
      d_in            = d_ff;
      verdict_in      = verdict_ff;
      count_in        = count_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_is_prime_in = rsp_is_prime_ff;
      div_start       = 1'b0;
      req_ready       = 1'b0;

      // Output register drains independently of the sequencer
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               n_in     = req_value[NW-1:0];
               state_in = ST_SCREEN;
            end
         end
         ST_SCREEN: begin
            // 2 is prime; below 2 and other even numbers are not
            if (n_ff == NW'(2)) begin
               verdict_in = 1'b1;
               state_in   = ST_FINISH;
            end else if ((n_ff < NW'(2)) || !n_ff[0]) begin
               verdict_in = 1'b0;
               state_in   = ST_FINISH;
            end else begin
               d_in      = NW'(3);
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               if (d_ff > quotient) begin
                  // divisor past the square root: no factor found
                  verdict_in = 1'b1;
                  state_in   = ST_FINISH;
               end else if (div_status.rem_zero) begin
                  verdict_in = 1'b0;
                  state_in   = ST_FINISH;
               end else begin
                  d_in      = d_ff + NW'(2);
                  div_start = 1'b1;
               end
            end
         end
         ST_FINISH: begin
            // wait for a free output slot, then count and publish
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_is_prime_in = verdict_ff;
               if (verdict_ff && (count_ff != COUNT_MAX)) begin
                  count_in = count_ff + COUNT_WIDTH'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_prime    = rsp_is_prime_ff;
   // count only moves when a verdict is loaded, so it doubles as the payload
   assign rsp_primes_seen = count_ff;

endmodule

>>> design/tdpt_divider.sv
// Bit-serial restoring divider for the trial-division prime test core.
// One quotient bit per cycle.
// Depends on tdpt_pkg.
module tdpt_divider
   import tdpt_pkg::*;
#(
   parameter int unsigned WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [WIDTH-1:0]    dividend,
   input  logic [WIDTH-1:0]    divisor,
   output logic [WIDTH-1:0]    quotient,
   output tdpt_div_status_type status
);

   localparam int unsigned CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] dvd_sr_ff, dvd_sr_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [WIDTH:0]   rem_shift;
   logic [WIDTH:0]   diff;
   logic             fits;

   assign rem_shift = {rem_ff, dvd_sr_ff[WIDTH-1]};
   assign diff      = rem_shift - {1'b0, divisor};
   assign fits      = (rem_shift >= {1'b0, divisor});

   always_comb begin
      dvd_sr_in = dvd_sr_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         dvd_sr_in = dividend;
         rem_in    = '0;
         quo_in    = '0;
         cnt_in    = CW'(WIDTH);
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         dvd_sr_in = {dvd_sr_ff[WIDTH-2:0], 1'b0};
         rem_in    = fits ? diff[WIDTH-1:0] : rem_shift[WIDTH-1:0];
         quo_in    = {quo_ff[WIDTH-2:0], fits};
         cnt_in    = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_sr_ff <= dvd_sr_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
   end

   assign quotient        = quo_ff;
   assign status.done     = done_ff;
   assign status.rem_zero = (rem_ff == '0);

endmodule

>>> design/tdpt_checker.sv
// Port-level checker for the trial-division prime test core, with its bind.
// Depends on tdpt_pkg and trial_division_prime_test_core.
module tdpt_checker
   import tdpt_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [VALUE_PORT_WIDTH-1:0] req_value,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_is_prime,
   input logic [COUNT_WIDTH-1:0]      rsp_primes_seen
);

   logic [VALUE_PORT_WIDTH-1:0] value_seen;
   assign value_seen = req_value;

   // Stalled transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_prime)
                                 && $stable(rsp_primes_seen))
      else $error("result changed while stalled");

   // One transaction in flight: no acceptance right after one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction accepted while busy, value %0h", $past(value_seen));

   // Count only steps by one, and only with a fresh prime verdict
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(rsp_primes_seen) |->
         rsp_primes_seen == COUNT_WIDTH'($past(rsp_primes_seen) + 1'b1)
         && rsp_is_prime && rsp_valid)
      else $error("prime count moved unexpectedly");

   // Saturated count stays put
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_primes_seen == COUNT_MAX |=> rsp_primes_seen == COUNT_MAX)
      else $error("prime count wrapped");

endmodule

bind trial_division_prime_test_core tdpt_checker u_tdpt_checker (.*);

>>> tb/tb_trial_division_prime_test_core.sv
// Testbench for trial_division_prime_test_core: directed and random numbers, random idling on
// both channels, one long receiver hold-off. Verdicts are checked against an in-bench predictor.
// Depends on tdpt_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_trial_division_prime_test_core
   import tdpt_pkg::*;
;

   localparam int unsigned VALUE_WIDTH = 32;
   // Cycles tolerated with no handshake on either channel before the watchdog ends the run.
   localparam int unsigned QUIET_LIMIT = 5_000_000;
   // Full-width random numbers whose trial count exceeds this are made even, keeping the run short.
   localparam int unsigned TRIAL_BUDGET = 200;
   localparam int unsigned RANDOM_ITEMS = 80;
   localparam int unsigned STALL_CYCLES = 300;

   typedef struct packed {
      logic                   is_prime;
      logic [COUNT_WIDTH-1:0] primes_seen;
   } verdict_type;

   logic                        clock     = 1'b0;
   logic                        reset     = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [VALUE_PORT_WIDTH-1:0] req_value = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic                        rsp_is_prime;
   logic [COUNT_WIDTH-1:0]      rsp_primes_seen;

   logic [VALUE_PORT_WIDTH-1:0] pending_values[$];
   verdict_type                 expected_verdicts[$];
   logic [COUNT_WIDTH-1:0]      primes_counted = '0;
   int unsigned                 values_issued = 0;
   int unsigned                 verdicts_checked = 0;
   int unsigned                 mismatch_count = 0;
   int unsigned                 stall_countdown = 0;
   logic                        stall_done = 1'b0;
   int unsigned                 quiet_cycles = 0;

   trial_division_prime_test_core #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_is_prime   (rsp_is_prime),
      .rsp_primes_seen(rsp_primes_seen)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Trial division on the low VALUE_WIDTH bits. The bound d <= n/d is the square test at
   // double width, so it cannot wrap near the top of the range. trials reports the number of
   // odd divisors tried, which tracks the core's latency.
   function automatic logic prime_verdict(input logic [VALUE_PORT_WIDTH-1:0] raw,
                                          output int unsigned trials);
      logic [63:0] mask;
      logic [63:0] n;
      logic [63:0] d;
      mask   = (64'd1 << VALUE_WIDTH) - 64'd1;
      n      = {32'd0, raw} & mask;
      trials = 0;
      if (n == 64'd2) return 1'b1;
      if (n < 64'd2 || !n[0]) return 1'b0;
      for (d = 64'd3; d <= n / d; d += 64'd2) begin
         trials++;
         if (n % d == 64'd0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Steady stretch: no idling on either side while transactions 40..69 go through.
   function automatic logic steady_stretch(input int unsigned count);
      return count >= 40 && count < 70;
   endfunction

   // Driver: offers pending numbers, predicts each verdict as its transaction is accepted.
   always @(posedge clock) begin
      logic        verdict;
      int unsigned trials;
      verdict_type entry;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            verdict = prime_verdict(req_value, trials);
            // count saturates rather than wrapping
            if (verdict && primes_counted != COUNT_MAX) primes_counted = primes_counted + 1'b1;
            entry.is_prime    = verdict;
            entry.primes_seen = primes_counted;
            expected_verdicts = {expected_verdicts, entry};
            values_issued++;
         end
         // payload held until accepted; only a free slot takes the next number
         if (!req_valid || req_ready) begin
            if (pending_values.size() != 0 &&
                (steady_stretch(values_issued) || $urandom_range(99) >= 15)) begin
               req_valid <= 1'b1;
               req_value <= pending_values.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted verdict against the oldest prediction and drives rsp_ready,
   // including one long hold-off so the output register fills and the input stalls.
   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               $error("rsp transaction with no verdict outstanding");
               mismatch_count++;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_is_prime !== want.is_prime) begin
                  $error("is_prime mismatch: expected %0d, actual %0d",
                         want.is_prime, rsp_is_prime);
                  mismatch_count++;
               end
               if (rsp_primes_seen !== want.primes_seen) begin
                  $error("primes_seen mismatch: expected %0d, actual %0d",
                         want.primes_seen, rsp_primes_seen);
                  mismatch_count++;
               end
            end
            verdicts_checked++;
         end
         if (stall_countdown != 0) begin
            stall_countdown--;
            rsp_ready <= 1'b0;
         end else if (!stall_done && verdicts_checked == 3) begin
            stall_done      <= 1'b1;
            stall_countdown = STALL_CYCLES;
            rsp_ready       <= 1'b0;
         end else begin
            rsp_ready <= steady_stretch(verdicts_checked) || $urandom_range(99) >= 15;
         end
      end
   end

   // Watchdog: ends the run if neither channel moves a transaction for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("trial_division_prime_test_core verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [VALUE_PORT_WIDTH-1:0] pick;
      int unsigned                 trials;

      // Directed: below 2, the only even prime, small primes and composites, squares of
      // primes (divisor exactly at the bound), all-zeros and all-ones, top-bit patterns,
      // the largest prime below 2**16 and the largest 32-bit prime.
      pending_values = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15, 32'd25,
                         32'd97, 32'd121, 32'd63001, 32'd65521, 32'd66049,
                         32'h8000_0000, 32'h8000_0001, 32'hAAAA_AAAA, 32'h5555_5555,
                         32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd4294967291};

      // Random: mostly small numbers, some up to 2**20, some full width with a small factor.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: pick = $urandom_range(4095);
            6, 7:             pick = $urandom_range(32'h000F_FFFF);
            default: begin
               pick = $urandom;
               void'(prime_verdict(pick, trials));
               if (trials > TRIAL_BUDGET) pick[0] = 1'b0;
            end
         endcase
         pending_values = {pending_values, pick};
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_values.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(negedge clock);
      // short drain so a stray extra verdict is still caught
      repeat (16) @(posedge clock);

      if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
         $display("trial_division_prime_test_core verification clean");
      end else begin
         $display("trial_division_prime_test_core verification failed");
      end
      $finish;
   end

endmodule
